// ===== design/brsfn_pkg.sv =====
// Shared constants, types and helper functions for the bitmap range set / find next block.
package brsfn_pkg;

    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = 64;
    localparam int CAP       = WORD_BITS * NUM_WORDS;

    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int USED_W = $clog2(NUM_WORDS + 1);

    localparam int OP_W   = 3;
    localparam int POS_W  = 12;
    localparam int END_W  = 13;
    localparam int FPOS_W = 13;

    localparam int CAP_W  = $clog2(CAP + 1);
    localparam int SPAN_W = (CAP_W > END_W) ? CAP_W : END_W;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_TEST      = 3'd0,
        OP_SET_BIT   = 3'd1,
        OP_SET_RANGE = 3'd2,
        OP_CLR_BIT   = 3'd3,
        OP_CLR_ALL   = 3'd4,
        OP_NEXT_SET  = 3'd5,
        OP_NEXT_CLR  = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_end;
        logic out_free;
    } dp_stat_t;

    // index of lowest set bit, binary narrowing
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] v;
        logic [WORD_BITS-1:0] m;
        logic [BIT_W-1:0]     idx;
        v   = w;
        idx = '0;
        for (int k = BIT_W - 1; k >= 0; k--)
        begin
            m = {WORD_BITS{1'b1}} >> (WORD_BITS - (1 << k));
            if ((v & m) == '0)
            begin
                idx[k] = 1'b1;
                v      = v >> (1 << k);
            end
        end
        return idx;
    endfunction

endpackage

// ===== design/brsfn_ctrl.sv =====
// Controller state machine: accept, word scan, result hand-off.
module brsfn_ctrl
    import brsfn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.need_scan ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/brsfn_dp.sv =====
// Datapath: bitmap word memory, used-word count, masks, search and result registers.
module brsfn_dp
    import brsfn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_stat_t          stat,
    input  logic [OP_W-1:0]   opcode,
    input  logic [POS_W-1:0]  position,
    input  logic [END_W-1:0]  range_end,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              bit_value,
    output logic              found,
    output logic [FPOS_W-1:0] found_position
);

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] vld_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_vld_reg;
    logic [ADDR_W-1:0]    rd_addr;

    op_t                  op_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [BIT_W-1:0]     hi_bit_reg;
    logic [ADDR_W-1:0]    start_w_reg;
    logic [ADDR_W-1:0]    last_w_reg;
    logic [ADDR_W-1:0]    cur_w_reg;
    logic [USED_W-1:0]    used_reg;

    logic                 res_bit_reg;
    logic                 res_found_reg;
    logic [FPOS_W-1:0]    res_fpos_reg;
    logic                 m_tvalid_reg;
    logic                 out_bit_reg;
    logic                 out_found_reg;
    logic [FPOS_W-1:0]    out_fpos_reg;

    // load-time decode
    op_t                  op_in;
    logic [SPAN_W-1:0]    pos_x;
    logic [SPAN_W-1:0]    end_x;
    logic [SPAN_W-1:0]    end_c;
    logic [SPAN_W-1:0]    endm1;
    logic [SPAN_W-1:0]    limit_x;
    logic [SPAN_W-1:0]    nc_pos;
    logic                 pos_in_map;
    logic                 need_scan;
    logic [ADDR_W-1:0]    start_w;
    logic [ADDR_W-1:0]    last_w;

    // per-word step
    logic [WORD_BITS-1:0] word;
    logic [BIT_W-1:0]     lo;
    logic [BIT_W-1:0]     hi;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] srch;
    logic                 is_search;
    logic                 hit;
    logic [BIT_W-1:0]     hit_idx;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    logic [USED_W-1:0]    cur_w_inc;
    logic                 out_free;

    assign op_in      = op_t'(opcode);
    assign pos_x      = SPAN_W'(position);
    assign end_x      = SPAN_W'(range_end);
    assign end_c      = (end_x > SPAN_W'(CAP)) ? SPAN_W'(CAP) : end_x;
    assign endm1      = end_c - SPAN_W'(1);
    assign limit_x    = SPAN_W'(used_reg) << BIT_W;
    assign nc_pos     = (pos_x < SPAN_W'(CAP)) ? pos_x : SPAN_W'(CAP);
    assign pos_in_map = pos_x < SPAN_W'(CAP);
    assign start_w    = ADDR_W'(pos_x >> BIT_W);

    always_comb
    begin
        need_scan = 1'b0;
        last_w    = start_w;
        case (op_in)
            OP_TEST, OP_SET_BIT, OP_CLR_BIT:
            begin
                need_scan = pos_in_map;
            end
            OP_SET_RANGE:
            begin
                need_scan = pos_in_map && (end_c > pos_x);
                last_w    = ADDR_W'(endm1 >> BIT_W);
            end
            OP_NEXT_SET, OP_NEXT_CLR:
            begin
                need_scan = pos_x < limit_x;
                last_w    = ADDR_W'(used_reg - USED_W'(1));
            end
            default:
            begin
                need_scan = 1'b0;
            end
        endcase
    end

    assign rd_addr = cmd.load ? start_w : (cur_w_reg + ADDR_W'(1));

    assign word      = rd_vld_reg ? rd_data_reg : '0;
    assign lo        = (cur_w_reg == start_w_reg) ? pos_reg[BIT_W-1:0] : '0;
    assign hi        = (cur_w_reg == last_w_reg) ? hi_bit_reg : {BIT_W{1'b1}};
    assign lo_mask   = {WORD_BITS{1'b1}} << lo;
    assign hi_mask   = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi);
    assign bit_mask  = WORD_BITS'(1) << pos_reg[BIT_W-1:0];
    assign is_search = op_reg inside {OP_NEXT_SET, OP_NEXT_CLR};
    assign srch      = ((op_reg == OP_NEXT_CLR) ? ~word : word) & lo_mask;
    assign hit       = is_search && (srch != '0);
    assign hit_idx   = lowest_set(srch);
    assign cur_w_inc = USED_W'(cur_w_reg) + USED_W'(1);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = word;
        case (op_reg)
            OP_SET_BIT:
            begin
                wr_en   = cmd.step;
                wr_data = word | bit_mask;
            end
            OP_SET_RANGE:
            begin
                wr_en   = cmd.step;
                wr_data = word | (lo_mask & hi_mask);
            end
            OP_CLR_BIT:
            begin
                wr_en   = cmd.step;
                wr_data = word & ~bit_mask;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign out_free       = !(m_tvalid_reg && !m_tready);
    assign stat.need_scan = need_scan;
    assign stat.scan_end  = (cur_w_reg == last_w_reg) || hit;
    assign stat.out_free  = out_free;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cur_w_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            used_reg   <= '0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rd_addr];
            if (cmd.load && (op_in == OP_CLR_ALL))
            begin
                vld_reg  <= '0;
                used_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[cur_w_reg] <= 1'b1;
                if ((op_reg != OP_CLR_BIT) && (cur_w_inc > used_reg))
                begin
                    used_reg <= cur_w_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg        <= op_in;
            pos_reg       <= position;
            hi_bit_reg    <= endm1[BIT_W-1:0];
            start_w_reg   <= start_w;
            last_w_reg    <= last_w;
            cur_w_reg     <= start_w;
            res_bit_reg   <= 1'b0;
            res_found_reg <= 1'b0;
            res_fpos_reg  <= '0;
            if (op_in == OP_NEXT_CLR)
            begin
                if (need_scan)
                begin
                    res_fpos_reg  <= FPOS_W'(limit_x);
                    res_found_reg <= limit_x < SPAN_W'(CAP);
                end
                else
                begin
                    res_fpos_reg  <= FPOS_W'(nc_pos);
                    res_found_reg <= nc_pos < SPAN_W'(CAP);
                end
            end
        end
        else if (cmd.step)
        begin
            if (!stat.scan_end)
            begin
                cur_w_reg <= cur_w_reg + ADDR_W'(1);
            end
            if (op_reg == OP_TEST)
            begin
                res_bit_reg <= word[pos_reg[BIT_W-1:0]];
            end
            if (hit)
            begin
                res_found_reg <= 1'b1;
                res_fpos_reg  <= FPOS_W'({cur_w_reg, hit_idx});
            end
        end
        if (cmd.emit)
        begin
            out_bit_reg   <= res_bit_reg;
            out_found_reg <= res_found_reg;
            out_fpos_reg  <= res_fpos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid       = m_tvalid_reg;
    assign bit_value      = out_bit_reg;
    assign found          = out_found_reg;
    assign found_position = out_fpos_reg;

    a_wr_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> cmd.step)
        else $error("memory write outside scan step");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(NUM_WORDS))
        else $error("used word count beyond map size");

    a_clr_all: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && (op_in == OP_CLR_ALL)) |=> ((used_reg == '0) && (vld_reg == '0)))
        else $error("clear all did not empty the map");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result overwrote a pending beat");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (cur_w_reg <= last_w_reg))
        else $error("scan ran past its last word");

endmodule

// ===== design/bitmap_range_set_find_next.sv =====
// Top level of the bitmap range set / find next block.
//
// Usage:
//   Slave stream: one beat per operation. s_tuser carries the opcode
//   (test, set bit, set range, clear bit, clear all, next set, next clear);
//   s_tdata carries the bit position and the exclusive range end.
//   Master stream: one result beat per operation, in order, with the tested
//   bit, the found flag and the found position.
// Scan:
//   An operation walks the words from its start word up to its last
//   word between accept and the result beat; test, set bit and clear
//   bit visit one word, clear all and trivial cases skip the scan. Set
//   range and the searches walk one word per cycle through the read and
//   write ports of the word memory, up to NUM_WORDS words, and a new beat
//   is accepted only once the result of the previous one is registered.
// Reset: the map reads all zero and the used-word count is zero at once;
//   per-word valid flags stand in for a clearing pass.
// Stall: a result waits in the output register while m_tready is low; the
//   next operation is still accepted and runs, then holds until it drains.
module bitmap_range_set_find_next
    import brsfn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [11:0] position, [24:12] range_end
    input  logic [S_TUSER_W-1:0] s_tuser,   // [2:0] opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [0] bit_value, [1] found, [14:2] found_position
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic              bit_value;
    logic              found;
    logic [FPOS_W-1:0] found_position;

    brsfn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brsfn_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (s_tuser[OP_W-1:0]),
        .position       (s_tdata[POS_W-1:0]),
        .range_end      (s_tdata[POS_W+END_W-1:POS_W]),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .bit_value      (bit_value),
        .found          (found),
        .found_position (found_position)
    );

    assign m_tdata = {{(M_TDATA_W - FPOS_W - 2){1'b0}}, found_position, found, bit_value};

endmodule
